FILE: rtl/h2t_pkg.sv
// Package: types and constants for the HTML-to-text filter.
package h2t_pkg;

	localparam int EntityMaxLenDefault = 6;
	localparam int QueueDepthDefault = 4;
	localparam logic [15:0] OutLimitReset = 16'd7000;
	localparam int MaxRes = 8;

	typedef enum logic [1:0] {
		MODE_TEXT = 2'd0,
		MODE_NAME = 2'd1,
		MODE_TAG  = 2'd2,
		MODE_SKIP = 2'd3
	} mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_doc;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       has_char;
		logic       last_out;
	} out_item_t;

	// One front-end step result: up to MaxRes characters.
	typedef struct packed {
		logic [MaxRes-1:0][7:0] chars;
		logic [3:0]             count;
		logic                   eod;
	} burst_t;

	function automatic logic [7:0] lower(input logic [7:0] c);
		lower = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] blk_char(input logic [1:0] k, input logic [2:0] p);
		logic [7:0] r;
		r = 8'h00;
		unique case (k)
			2'd0: unique case (p)
				3'd0: r = "s"; 3'd1: r = "c"; 3'd2: r = "r";
				3'd3: r = "i"; 3'd4: r = "p"; 3'd5: r = "t";
				default: r = 8'h00;
			endcase
			2'd1: unique case (p)
				3'd0: r = "s"; 3'd1: r = "t"; 3'd2: r = "y";
				3'd3: r = "l"; 3'd4: r = "e";
				default: r = 8'h00;
			endcase
			2'd2: unique case (p)
				3'd0: r = "s"; 3'd1: r = "v"; 3'd2: r = "g";
				default: r = 8'h00;
			endcase
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] blk_len(input logic [1:0] k);
		unique case (k)
			2'd0: return 3'd6;
			2'd1: return 3'd5;
			2'd2: return 3'd3;
			default: return 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] ent_char(input logic [2:0] k, input logic [2:0] p);
		logic [47:0] s;
		s = 48'h0;
		unique case (k)
			3'd0: s = "&nbsp;";
			3'd1: s = {"&amp;", 8'h0};
			3'd2: s = {"&lt;", 16'h0};
			3'd3: s = {"&gt;", 16'h0};
			3'd4: s = "&quot;";
			3'd5: s = {"&#39;", 8'h0};
			default: s = 48'h0;
		endcase
		return s[8*(5-p) +: 8];
	endfunction

	function automatic logic [2:0] ent_len(input logic [2:0] k);
		unique case (k)
			3'd0: return 3'd6;
			3'd1: return 3'd5;
			3'd2: return 3'd4;
			3'd3: return 3'd4;
			3'd4: return 3'd6;
			3'd5: return 3'd5;
			default: return 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] ent_out(input logic [2:0] k);
		unique case (k)
			3'd0: return 8'h20;
			3'd1: return 8'h26;
			3'd2: return 8'h3c;
			3'd3: return 8'h3e;
			3'd4: return 8'h22;
			3'd5: return 8'h27;
			default: return 8'h00;
		endcase
	endfunction

endpackage

FILE: rtl/h2t_front.sv
// Front end: parses one byte per cycle, while the burst queue has room, into a burst of text characters.
module h2t_front import h2t_pkg::*; #(
	parameter int EntityMaxLen = EntityMaxLenDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  in_item_t   in_item,
	output logic       in_stall,
	input  logic [15:0] out_limit,
	output logic       q_wr,
	output burst_t     q_wdata,
	input  logic       q_full
);

	localparam int LW = $clog2(EntityMaxLen + 1);

	mode_t        mode_q;
	logic [2:0]   cand_q;
	logic [2:0]   npos_q;
	logic [1:0]   skip_q;
	logic [3:0]   cpos_q;
	logic         pend_q;
	logic         emit_q;
	logic         resume_q;
	logic [EntityMaxLen-1:0][7:0] ebuf_q;
	logic [LW-1:0] elen_q;
	logic [15:0]  cnt_q;

	mode_t        mode_d;
	logic [2:0]   cand_d;
	logic [2:0]   npos_d;
	logic [1:0]   skip_d;
	logic [3:0]   cpos_d;
	logic         pend_d;
	logic         emit_d;
	logic         resume_d;
	logic [EntityMaxLen-1:0][7:0] ebuf_d;
	logic [LW-1:0] elen_d;
	logic [15:0]  cnt_d;
	burst_t       bo;

	logic acc;
	assign in_stall = q_full;
	assign acc = in_valid && !q_full;

	always_comb begin
		logic [7:0] b, lc, cc, e, tch, c;
		logic [2:0] alive;
		logic [1:0] hit;
		logic [2:0] bl, n;
		logic ws, is_text, pre_flush, set_pend, ok, m1, m2, tail, sp;
		logic [2:0] mk;
		logic [LW-1:0] slen;
		logic [3:0] sl, want, k4;
		logic [15:0] avail;
		mode_d = mode_q; cand_d = cand_q; npos_d = npos_q; skip_d = skip_q;
		cpos_d = cpos_q; pend_d = pend_q; emit_d = emit_q; resume_d = resume_q;
		ebuf_d = ebuf_q; elen_d = elen_q; cnt_d = cnt_q;
		bo = '0;
		b = in_item.in_byte;
		lc = lower(b);
		pre_flush = 1'b0; set_pend = 1'b0; is_text = 1'b0;
		alive = '0; hit = '0; cc = '0; bl = '0; n = '0; c = '0;
		ok = 1'b0; m1 = 1'b0; m2 = 1'b0; mk = '0; e = '0;
		tail = 1'b0; tch = '0; slen = '0; sp = 1'b0; sl = '0; want = '0; k4 = '0;
		avail = '0;
		ws = (b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0a);
		unique case (mode_q)
			MODE_TEXT: begin
				if (b == "<") begin
					resume_d = 1'b0; mode_d = MODE_NAME; cand_d = 3'b111; npos_d = '0;
				end else if (b == ">") begin
				end else if (ws) begin
					pre_flush = 1'b1; set_pend = 1'b1;
				end else begin
					is_text = 1'b1;
				end
			end
			MODE_TAG: begin
				if (b == "<") begin
					resume_d = 1'b1; mode_d = MODE_NAME; cand_d = 3'b111; npos_d = '0;
				end else if (b == ">") mode_d = MODE_TEXT;
			end
			MODE_NAME: begin
				for (int k = 0; k < 3; k++) begin
					if (cand_q[k] && npos_q < blk_len(2'(k)) && blk_char(2'(k), npos_q) == lc) begin
						alive[k] = 1'b1;
						if (npos_q + 3'd1 == blk_len(2'(k))) hit = 2'(k + 1);
					end
				end
				if (hit != 2'd0) begin
					mode_d = MODE_SKIP; skip_d = hit; cpos_d = '0;
				end else if (alive != 3'd0) begin
					cand_d = alive; npos_d = npos_q + 3'd1;
				end else begin
					pre_flush = 1'b1; set_pend = 1'b1; mode_d = MODE_TAG;
					if (b == "<") begin
						resume_d = 1'b1; mode_d = MODE_NAME; cand_d = 3'b111; npos_d = '0;
					end else if (b == ">") mode_d = MODE_TEXT;
				end
			end
			MODE_SKIP: begin
				if (skip_q == 2'd0) begin
					mode_d = resume_q ? MODE_TAG : MODE_TEXT; cpos_d = '0;
				end else begin
					bl = blk_len(skip_q - 2'd1);
					if (cpos_q == 4'd0) cc = "<";
					else if (cpos_q == 4'd1) cc = "/";
					else if (cpos_q < {1'b0, bl} + 4'd2)
						cc = blk_char(skip_q - 2'd1, 3'(cpos_q - 4'd2));
					else cc = ">";
					if (cpos_q <= {1'b0, bl} + 4'd2 && lc == cc) begin
						cpos_d = cpos_q + 4'd1;
						if (cpos_d == {1'b0, bl} + 4'd3) begin
							mode_d = resume_q ? MODE_TAG : MODE_TEXT;
							skip_d = '0; cpos_d = '0;
						end
					end else cpos_d = (b == "<") ? 4'd1 : 4'd0;
				end
			end
			default: ;
		endcase

		// Entity extension when a text byte arrives with held entity text.
		if (is_text && elen_q != '0) begin
			if (elen_q < LW'(EntityMaxLen)) begin
				ebuf_d[elen_q] = b;
				n = 3'(elen_q) + 3'd1;
				for (int k = 5; k >= 0; k--) begin
					ok = n <= ent_len(3'(k));
					for (int i = 0; i < EntityMaxLen; i++)
						if (i < n && ent_char(3'(k), 3'(i)) != ebuf_d[i]) ok = 1'b0;
					if (ok) begin
						if (n == ent_len(3'(k))) begin m2 = 1'b1; mk = 3'(k); end
						else m1 = 1'b1;
					end
				end
				if (m2) begin
					elen_d = '0; is_text = 1'b0; e = ent_out(mk);
				end else if (m1) begin
					elen_d = LW'(n); is_text = 1'b0;
				end else pre_flush = 1'b1;
			end else pre_flush = 1'b1;
		end

		// Characters put this step: an optional pending space, slen held bytes, then an optional tail.
		if (pre_flush) begin
			slen = elen_q; tail = is_text && (b != "&" || in_item.end_of_doc); tch = b;
		end else if (m2) begin
			tail = 1'b1; tch = e;
		end else if (m1) begin
			slen = in_item.end_of_doc ? LW'(n) : '0;
		end else if (is_text) begin
			tail = b != "&" || in_item.end_of_doc; tch = b;
		end else begin
			slen = in_item.end_of_doc ? elen_q : '0;
		end
		if (pre_flush) elen_d = '0;
		if (is_text && b == "&") begin ebuf_d[0] = b; elen_d = LW'(1); end

		sl = 4'(slen) + {3'b0, tail};
		sp = pend_q && emit_q && sl != 4'd0;
		want = sl + {3'b0, sp};
		avail = (out_limit > cnt_q) ? out_limit - cnt_q : 16'd0;
		bo.count = (avail < 16'(want)) ? avail[3:0] : want;
		for (int j = 0; j < MaxRes; j++) begin
			k4 = 4'(j) - {3'b0, sp};
			if (sp && j == 0) c = 8'h20;
			else if (k4 < 4'(slen)) c = (k4 < 4'(elen_q)) ? ebuf_q[LW'(k4)] : b;
			else c = tch;
			if (4'(j) < bo.count) bo.chars[j] = c;
		end
		cnt_d = cnt_q + 16'(bo.count);
		if (sl != 4'd0) begin
			emit_d = 1'b1; pend_d = 1'b0;
		end
		if (set_pend) pend_d = 1'b1;

		bo.eod = in_item.end_of_doc;
		if (in_item.end_of_doc) begin
			mode_d = MODE_TEXT; cand_d = '0; npos_d = '0; skip_d = '0; cpos_d = '0;
			pend_d = 1'b0; emit_d = 1'b0; elen_d = '0; cnt_d = '0; resume_d = 1'b0;
		end
	end

	assign q_wr = acc && (bo.count != 4'd0 || bo.eod);
	assign q_wdata = bo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TEXT; cand_q <= '0; npos_q <= '0; skip_q <= '0;
			cpos_q <= '0; pend_q <= 1'b0; emit_q <= 1'b0; resume_q <= 1'b0;
			elen_q <= '0; cnt_q <= '0;
		end else if (acc) begin
			mode_q <= mode_d; cand_q <= cand_d; npos_q <= npos_d; skip_q <= skip_d;
			cpos_q <= cpos_d; pend_q <= pend_d; emit_q <= emit_d; resume_q <= resume_d;
			elen_q <= elen_d; cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) ebuf_q <= ebuf_d;
	end

endmodule

FILE: rtl/h2t_queue.sv
// Small FIFO of character bursts between front and back end.
module h2t_queue import h2t_pkg::*; #(
	parameter int Depth = QueueDepthDefault
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr,
	input  burst_t wdata,
	output logic   full,
	input  logic   rd,
	output burst_t rdata,
	output logic   empty
);

	localparam int AW = $clog2(Depth);

	burst_t        mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full = cnt_q == (AW+1)'(Depth);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

endmodule

FILE: rtl/h2t_back.sv
// Back end: serializes a burst into output items through an output register.
module h2t_back import h2t_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  burst_t    q_rdata,
	input  logic      q_empty,
	output logic      q_rd,
	output logic      out_valid,
	output out_item_t out_item,
	input  logic      out_stall
);

	logic [3:0] idx_q;
	logic       load, last;

	assign load = !q_empty && (!out_valid || !out_stall);
	assign last = q_rdata.count == 4'd0 || idx_q + 4'd1 >= q_rdata.count;
	assign q_rd = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0; idx_q <= '0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				idx_q <= last ? 4'd0 : idx_q + 4'd1;
			end else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_item.has_char <= q_rdata.count != 4'd0;
			out_item.out_char <= (q_rdata.count != 4'd0) ? q_rdata.chars[idx_q[2:0]] : 8'h00;
			out_item.last_out <= last && q_rdata.eod;
		end
	end

endmodule

FILE: rtl/html_to_text_filter_core.sv
// Top level of the HTML-to-text filter.
// Input channel: in_valid/in_stall carry one raw HTML byte per item, with
// end_of_doc on the final byte of a document. Output channel: out_valid/
// out_stall carry one text character per item; a document's last item has
// last_out set, and is a bare marker (has_char 0) if the last byte made no text.
// An APB port holds out_limit at address 0 (reset 7000).
// The front end takes one byte per cycle when the burst queue has room; each
// byte makes 0 to 8 characters. The back end sends one item per cycle from
// the queue head while out_stall is low, so throughput is one byte per cycle
// while bytes give at most one character each. The first item of a byte
// is written to the burst queue, then loaded into the back end's output register.
// A stalled output holds its item; the queue fills, then in_stall rises.
// Reset clears the queue and all parse state but ebuf_q, and sets out_limit to 7000.
module html_to_text_filter_core import h2t_pkg::*; #(
	parameter int EntityMaxLen = EntityMaxLenDefault,
	parameter int QueueDepth = QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  in_item_t    in_item,
	output logic        in_stall,
	output logic        out_valid,
	output out_item_t   out_item,
	input  logic        out_stall,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] limit_q;
	logic        q_wr, q_full, q_rd, q_empty;
	burst_t      q_wdata, q_rdata;

	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {16'h0, limit_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= OutLimitReset;
		else if (psel && penable && pwrite && paddr == 1'b0) limit_q <= pwdata[15:0];
	end

	h2t_front #(.EntityMaxLen(EntityMaxLen)) u_front (
		.clk, .arst_n, .in_valid, .in_item, .in_stall,
		.out_limit(limit_q), .q_wr, .q_wdata, .q_full
	);

	h2t_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .wr(q_wr), .wdata(q_wdata), .full(q_full),
		.rd(q_rd), .rdata(q_rdata), .empty(q_empty)
	);

	h2t_back u_back (
		.clk, .arst_n, .q_rdata, .q_empty, .q_rd, .out_valid, .out_item, .out_stall
	);

endmodule

FILE: tb/tb_html_to_text_filter_core.sv
// Testbench for the HTML-to-text filter core: directed table plus random documents, checked by a predictor.
module tb_html_to_text_filter_core;
	import h2t_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	in_item_t in_item;
	out_item_t out_item;
	logic psel, penable, pwrite;
	logic [0:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	html_to_text_filter_core DUT (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// predictor state
	logic [15:0] lim;
	mode_t pmode;
	logic [2:0] cand, npos;
	logic [1:0] skind;
	logic [3:0] cpos;
	bit pend, any, rtag;
	logic [7:0] ebuf[6];
	int elen, ocount;
	out_item_t text_q[$];
	int nres;
	string got_txt;

	int errors, n_in, n_out, n_docs, idle_cycles, lull, hold;
	bit calm;

	task automatic report(string msg);
		errors++;
		$display("mismatch %s", msg);
	endtask

	function automatic void add_exp(out_item_t r);
		text_q = {text_q, r};
	endfunction

	function automatic void put_raw(logic [7:0] c);
		out_item_t r;
		if (ocount < lim && nres < MaxRes) begin
			r.out_char = c; r.has_char = 1; r.last_out = 0;
			add_exp(r);
			nres++; ocount++;
		end
	endfunction

	function automatic void put_text(logic [7:0] c);
		if (pend && any) put_raw(8'h20);
		pend = 0;
		put_raw(c);
		any = 1;
	endfunction

	function automatic void flush_ent();
		for (int i = 0; i < elen; i++) put_text(ebuf[i]);
		elen = 0;
	endfunction

	function automatic string ent_str(int k);
		case (k)
			0: return "&nbsp;"; 1: return "&amp;"; 2: return "&lt;";
			3: return "&gt;"; 4: return "&quot;"; default: return "&#39;";
		endcase
	endfunction

	function automatic logic [7:0] ent_val(int k);
		case (k)
			0: return " "; 1: return "&"; 2: return "<";
			3: return ">"; 4: return "\""; default: return "'";
		endcase
	endfunction

	function automatic void text_char(logic [7:0] c);
		int n, full;
		bit pre, ok;
		string s;
		if (elen > 0) begin
			if (elen < 6) begin
				n = elen + 1;
				ebuf[elen] = c;
				pre = 0; full = -1;
				for (int k = 0; k < 6; k++) begin
					s = ent_str(k);
					ok = n <= s.len();
					for (int i = 0; ok && i < n; i++) if (s[i] != ebuf[i]) ok = 0;
					if (ok && n == s.len() && full < 0) full = k;
					else if (ok) pre = 1;
				end
				if (full >= 0) begin
					elen = 0;
					put_text(ent_val(full));
					return;
				end
				if (pre) begin
					elen = n;
					return;
				end
			end
			flush_ent();
		end
		if (c == "&") begin
			ebuf[0] = c;
			elen = 1;
			return;
		end
		put_text(c);
	endfunction

	function automatic string blk(int k);
		case (k)
			0: return "script"; 1: return "style"; default: return "svg";
		endcase
	endfunction

	function automatic void start_name(bit t);
		rtag = t; pmode = MODE_NAME; cand = 3'b111; npos = 0;
	endfunction

	function automatic void tag_byte(logic [7:0] b);
		if (b == "<") start_name(1);
		else if (b == ">") pmode = MODE_TEXT;
	endfunction

	function automatic void reset_doc();
		pmode = MODE_TEXT; cand = 0; npos = 0; skind = 0; cpos = 0;
		pend = 0; any = 0; elen = 0; ocount = 0; rtag = 0;
	endfunction

	function automatic void predict(in_item_t it);
		logic [7:0] b, lc, want;
		logic [2:0] alive;
		int hit, len;
		string s;
		out_item_t r;
		b = it.in_byte;
		lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		nres = 0;
		case (pmode)
			MODE_TEXT:
				if (b == "<") start_name(0);
				else if (b == ">") ;
				else if (b == " " || b == 8'h09 || b == 8'h0d || b == 8'h0a) begin
					flush_ent(); pend = 1;
				end else text_char(b);
			MODE_TAG: tag_byte(b);
			MODE_NAME: begin
				alive = 0; hit = 0;
				for (int k = 0; k < 3; k++) begin
					s = blk(k);
					if (cand[k] && npos < s.len() && s[npos] == lc) begin
						alive[k] = 1;
						if (npos + 1 == s.len()) hit = k + 1;
					end
				end
				if (hit != 0) begin
					pmode = MODE_SKIP; skind = hit; cpos = 0;
				end else if (alive != 0) begin
					cand = alive; npos++;
				end else begin
					flush_ent(); pend = 1; pmode = MODE_TAG; tag_byte(b);
				end
			end
			default: begin
				s = blk(skind - 1);
				len = s.len();
				if (cpos == 0) want = "<";
				else if (cpos == 1) want = "/";
				else if (cpos < len + 2) want = s[cpos - 2];
				else want = ">";
				if (cpos <= len + 2 && lc == want) begin
					cpos++;
					if (cpos == len + 3) begin
						pmode = rtag ? MODE_TAG : MODE_TEXT; skind = 0; cpos = 0;
					end
				end else cpos = (b == "<") ? 1 : 0;
			end
		endcase
		if (it.end_of_doc) begin
			flush_ent();
			if (nres == 0) begin
				r = '0; r.last_out = 1;
				add_exp(r);
			end else text_q[$].last_out = 1;
			reset_doc();
		end
	endfunction

	// accept tracking and checking
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict(in_item);
				n_in++;
			end
			if (out_valid && !out_stall) begin
				n_out++;
				if (out_item.last_out) n_docs++;
				if (out_item.has_char) got_txt = {got_txt, string'(out_item.out_char)};
				if (text_q.size() == 0)
					report($sformatf("unexpected item %h/%b/%b", out_item.out_char,
						out_item.has_char, out_item.last_out));
				else begin
					e = text_q.pop_front();
					if (out_item !== e)
						report($sformatf("got %h/%b/%b expected %h/%b/%b",
							out_item.out_char, out_item.has_char, out_item.last_out,
							e.out_char, e.has_char, e.last_out));
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles > 3000) begin
				$display("watchdog: no progress");
				$display("simulation failed");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, plus one long hold
	always @(posedge clk) begin
		if (!arst_n) out_stall <= 0;
		else if (hold > 0) begin
			hold--;
			out_stall <= 1;
		end else if (calm) out_stall <= 0;
		else if (lull > 0) begin
			lull--;
			out_stall <= 1;
		end else if ($urandom_range(0, 5) == 0) begin
			lull = $urandom_range(0, 3);
			out_stall <= 1;
		end else out_stall <= 0;
	end

	task automatic send(logic [7:0] b, bit eod);
		if (!calm && $urandom_range(0, 6) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		in_item.in_byte <= b;
		in_item.end_of_doc <= eod;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_str(string s, bit eod);
		for (int i = 0; i < s.len(); i++) send(s[i], eod && i == s.len() - 1);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (text_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limit(logic [15:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 0; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		lim = v;
		@(posedge clk);
	endtask

	function automatic string rand_doc();
		string s, frag;
		int parts;
		s = "";
		parts = $urandom_range(1, 5);
		for (int p = 0; p < parts; p++) begin
			case ($urandom_range(0, 9))
				0: frag = "<p>";
				1: frag = $urandom_range(0, 1) ? "<ScRiPt>x<b></script>" : "<style>a{}</STYLE>";
				2: frag = "<svg><g/></svg";
				3: frag = ent_str($urandom_range(0, 5));
				4: frag = " \t\r\n";
				5: frag = "<a <svg>q</svg> b>";
				6: frag = "&am p";
				7: frag = ">";
				default: begin
					frag = "";
					repeat ($urandom_range(1, 4))
						frag = {frag, string'(byte'($urandom_range(0, 1) ?
							$urandom_range(8'h61, 8'h7a) : $urandom_range(0, 255)))};
				end
			endcase
			s = {s, frag};
		end
		return s;
	endfunction

	typedef struct {
		string txt;
		string exp;
	} row_t;

	row_t rows[] = '{
		'{"x", "x"},
		'{">", ""},
		'{"  a  b ", "a b"},
		'{"a<b>c", "a c"},
		'{"&amp;&lt;&gt;&quot;&#39;", "&<>\"'"},
		'{"&nbsp;x", " x"},
		'{"&amp;lt;", "&lt;"},
		'{"&am b", "&am b"},
		'{"a<SCRIPT>z</ScRiPt>b", "ab"},
		'{"a<style>z</style>b", "ab"},
		'{"a<svg>zz", "a"},
		'{"a<p", "a"},
		'{"<i <svg>>x</svg> >t", "t"},
		'{"&a<style></style>mp;", "&"},
		'{string'({8'hff, 8'h01, 8'h80}), string'({8'hff, 8'h01, 8'h80})}
	};

	initial begin
		errors = 0; n_in = 0; n_out = 0; n_docs = 0; idle_cycles = 0; lull = 0; hold = 0;
		calm = 0; got_txt = "";
		in_valid = 0; in_item = '0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		lim = OutLimitReset;
		reset_doc();
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[r]) begin
			got_txt = "";
			send_str(rows[r].txt, 1);
			drain();
			if (got_txt != rows[r].exp)
				report($sformatf("row %0d: got \"%s\" expected \"%s\"", r, got_txt,
					rows[r].exp));
		end

		set_limit(16'd0);
		send_str("abc", 1);
		drain();
		set_limit(16'd3);
		send_str("ab cd", 1);
		drain();
		set_limit(16'hffff);

		// long receiver hold while bytes keep coming
		fork
			hold = 80;
			send_str("abcdefghijklmnopqrstuvwxyz0123456789", 1);
		join
		drain();

		while (n_in < 230) begin
			if (n_in > 215) calm = 1;
			if ($urandom_range(0, 15) == 0) begin
				drain();
				set_limit($urandom_range(0, 1) ? 16'($urandom_range(1, 12)) : 16'hffff);
			end
			send_str(rand_doc(), 1);
		end
		drain();

		$display("%0d bytes in, %0d items out, %0d documents", n_in, n_out, n_docs);
		$display("limits 0..65535, entities, skipped blocks, stalls and long hold covered");
		if (errors == 0 && text_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
